// ===== design/ogw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogw_pkg
// Shared types and constants of the OLED command and GDDRAM writer.
// ----------------------------------------------------------------------------
package ogw_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 64;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic       func;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic       write_valid;
    logic [5:0] pixel_row;
    logic [6:0] pixel_col;
    logic       pixel_on;
    logic       screen_on;
    logic       inverted;
    logic       last;
  } out_t;

  // One queued job: cnt visible pixels starting at row0, stepping by flip.
  typedef struct packed {
    logic [3:0] cnt;
    logic [5:0] row0;
    logic       flip;
    logic [6:0] col;
    logic [7:0] data;
    logic       disp;
    logic       inv;
  } job_t;

endpackage

// ===== design/ogw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogw_front
// Decodes command, parameter and data beats, keeps the controller state and
// the cursor, and turns every accepted beat into one job for the emitter.
// ----------------------------------------------------------------------------
module ogw_front
  import ogw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_t        in_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output job_t       job
);

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_POLARITY = 2'd2;

  localparam logic [7:0] CMD_ADDR_MODE = 8'h20;
  localparam logic [7:0] CMD_COL_WIN   = 8'h21;
  localparam logic [7:0] CMD_PAGE_WIN  = 8'h22;
  localparam logic [7:0] CMD_CONTRAST  = 8'h81;
  localparam logic [7:0] CMD_SEG_NORM  = 8'hA0;
  localparam logic [7:0] CMD_SEG_REMAP = 8'hA1;
  localparam logic [7:0] CMD_NORMAL    = 8'hA6;
  localparam logic [7:0] CMD_INVERSE   = 8'hA7;
  localparam logic [7:0] CMD_MUX_RATIO = 8'hA8;
  localparam logic [7:0] CMD_DISP_OFF  = 8'hAE;
  localparam logic [7:0] CMD_DISP_ON   = 8'hAF;
  localparam logic [7:0] CMD_COM_NORM  = 8'hC0;
  localparam logic [7:0] CMD_COM_FLIP  = 8'hC8;
  localparam logic [7:0] CMD_OFFSET    = 8'hD3;
  localparam logic [7:0] CMD_CLOCK_DIV = 8'hD5;
  localparam logic [7:0] CMD_PRECHARGE = 8'hD9;
  localparam logic [7:0] CMD_COM_PINS  = 8'hDA;
  localparam logic [7:0] CMD_VCOMH     = 8'hDB;

  localparam logic [1:0] MODE_HORIZ = 2'd0;
  localparam logic [1:0] MODE_VERT  = 2'd1;
  localparam logic [1:0] MODE_PAGE  = 2'd2;

  localparam logic [7:0] RST_COL_END = 8'(MAX_WIDTH - 1);
  localparam logic [11:0] RST_ROW_END = 12'(MAX_HEIGHT - 1);

  logic [7:0]  width_r, height_r_unused;
  logic [6:0]  height_r;
  logic        polarity_r;
  logic [1:0]  addr_mode_r, addr_mode_nxt;
  logic        seg_remap_r, seg_remap_nxt;
  logic        com_flip_r, com_flip_nxt;
  logic [1:0]  params_left_r, params_left_nxt;
  logic [7:0]  pend_cmd_r, pend_cmd_nxt;
  logic [1:0]  param_cnt_r, param_cnt_nxt;
  logic [7:0]  win_col_start_r, win_col_start_nxt;
  logic [7:0]  win_col_end_r, win_col_end_nxt;
  logic [11:0] win_row_start_r, win_row_start_nxt;
  logic [11:0] win_row_end_r, win_row_end_nxt;
  logic [7:0]  cur_col_r, cur_col_nxt;
  logic [11:0] cur_row_r, cur_row_nxt;
  logic [3:0]  col_low_r, col_low_nxt;
  logic [3:0]  col_high_r, col_high_nxt;
  logic        disp_en_r, disp_en_nxt;
  logic        inv_r, inv_nxt;

  logic [7:0]  eff_w;
  logic [6:0]  eff_h;
  logic [7:0]  b;
  logic [7:0]  nib_c;
  logic [8:0]  c9;
  logic [12:0] r13;
  logic [10:0] page_end;
  logic        visible;
  logic [6:0]  rem;
  logic [7:0]  pcol;
  logic [6:0]  prow;

  assign height_r_unused = {1'b0, height_r};
  assign b = in_data.byte_value;

  always_comb begin
    eff_w = width_r;
    if (width_r == 8'd0) begin
      eff_w = 8'd1;
    end else if ({1'b0, width_r} > 9'(MAX_WIDTH)) begin
      eff_w = 8'(MAX_WIDTH);
    end
    eff_h = height_r;
    if (height_r == 7'd0) begin
      eff_h = 7'd1;
    end else if (height_r_unused > 8'(MAX_HEIGHT)) begin
      eff_h = 7'(MAX_HEIGHT);
    end
  end

  always_comb begin
    addr_mode_nxt     = addr_mode_r;
    seg_remap_nxt     = seg_remap_r;
    com_flip_nxt      = com_flip_r;
    params_left_nxt   = params_left_r;
    pend_cmd_nxt      = pend_cmd_r;
    param_cnt_nxt     = param_cnt_r;
    win_col_start_nxt = win_col_start_r;
    win_col_end_nxt   = win_col_end_r;
    win_row_start_nxt = win_row_start_r;
    win_row_end_nxt   = win_row_end_r;
    cur_col_nxt       = cur_col_r;
    cur_row_nxt       = cur_row_r;
    col_low_nxt       = col_low_r;
    col_high_nxt      = col_high_r;
    disp_en_nxt       = disp_en_r;
    inv_nxt           = inv_r;
    nib_c             = 8'd0;
    c9                = {1'b0, cur_col_r} + 9'd1;
    r13               = {1'b0, cur_row_r} + 13'd8;
    page_end          = {b, 3'b111};

    if (in_data.func) begin
      unique case (addr_mode_r)
        MODE_HORIZ: begin
          if (c9 > {1'b0, win_col_end_r}) begin
            cur_col_nxt = win_col_start_r;
            if (r13 > {1'b0, win_row_end_r}) begin
              cur_row_nxt = win_row_start_r;
            end else begin
              cur_row_nxt = r13[11:0];
            end
          end else begin
            cur_col_nxt = c9[7:0];
          end
        end
        MODE_VERT: begin
          if (r13 > {1'b0, win_row_end_r}) begin
            cur_row_nxt = win_row_start_r;
            if (c9 > {1'b0, win_col_end_r}) begin
              cur_col_nxt = win_col_start_r;
            end else begin
              cur_col_nxt = c9[7:0];
            end
          end else begin
            cur_row_nxt = r13[11:0];
          end
        end
        default: begin
          if (c9 > {1'b0, win_col_end_r}) begin
            cur_col_nxt = win_col_start_r;
          end else begin
            cur_col_nxt = c9[7:0];
          end
        end
      endcase
    end else if (params_left_r != 2'd0) begin
      params_left_nxt = params_left_r - 2'd1;
      unique case (pend_cmd_r)
        CMD_ADDR_MODE: addr_mode_nxt = b[1:0];
        CMD_COL_WIN: begin
          if (param_cnt_r == 2'd0) begin
            win_col_start_nxt = b;
            cur_col_nxt       = b;
          end else begin
            win_col_end_nxt = b;
          end
        end
        CMD_PAGE_WIN: begin
          if (param_cnt_r == 2'd0) begin
            win_row_start_nxt = {1'b0, b, 3'b000};
            cur_row_nxt       = {1'b0, b, 3'b000};
          end else begin
            if (page_end >= {4'd0, eff_h}) begin
              page_end = {4'd0, eff_h} - 11'd1;
            end
            win_row_end_nxt = {1'b0, page_end};
          end
        end
        default: ;
      endcase
      if (param_cnt_r != 2'd3) begin
        param_cnt_nxt = param_cnt_r + 2'd1;
      end
    end else begin
      pend_cmd_nxt    = b;
      param_cnt_nxt   = 2'd0;
      params_left_nxt = 2'd0;
      priority if (b <= 8'h0F) begin
        col_low_nxt = b[3:0];
        nib_c       = {col_high_r, b[3:0]};
        cur_col_nxt = (nib_c >= eff_w) ? eff_w - 8'd1 : nib_c;
      end else if (b <= 8'h1F) begin
        col_high_nxt = b[3:0];
        nib_c        = {b[3:0], col_low_r};
        cur_col_nxt  = (nib_c >= eff_w) ? eff_w - 8'd1 : nib_c;
      end else if (b >= 8'h40 && b <= 8'h7F) begin
        cur_col_nxt = cur_col_r;
      end else if (b >= 8'hB0 && b <= 8'hB7) begin
        cur_row_nxt = {6'd0, b[2:0], 3'b000};
        cur_col_nxt = win_col_start_r;
      end else begin
        unique case (b)
          CMD_DISP_OFF:  disp_en_nxt = 1'b0;
          CMD_DISP_ON:   disp_en_nxt = 1'b1;
          CMD_NORMAL:    inv_nxt = polarity_r;
          CMD_INVERSE:   inv_nxt = ~polarity_r;
          CMD_SEG_NORM:  seg_remap_nxt = 1'b0;
          CMD_SEG_REMAP: seg_remap_nxt = 1'b1;
          CMD_COM_NORM:  com_flip_nxt = 1'b0;
          CMD_COM_FLIP:  com_flip_nxt = 1'b1;
          CMD_ADDR_MODE: params_left_nxt = 2'd1;
          CMD_COL_WIN, CMD_PAGE_WIN: params_left_nxt = 2'd2;
          CMD_CONTRAST, CMD_MUX_RATIO, CMD_OFFSET, CMD_CLOCK_DIV,
          CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: params_left_nxt = 2'd1;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    visible = (cur_col_r < eff_w) && (cur_row_r < {5'd0, eff_h});
    rem     = eff_h - cur_row_r[6:0];
    pcol    = eff_w - 8'd1 - cur_col_r;
    prow    = eff_h - 7'd1 - cur_row_r[6:0];
    job.cnt  = 4'd0;
    job.row0 = com_flip_r ? prow[5:0] : cur_row_r[5:0];
    job.flip = com_flip_r;
    job.col  = seg_remap_r ? pcol[6:0] : cur_col_r[6:0];
    job.data = b;
    job.disp = disp_en_nxt;
    job.inv  = inv_nxt;
    if (in_data.func && visible) begin
      job.cnt = (rem >= 7'd8) ? 4'd8 : rem[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r         <= 8'd128;
      height_r        <= 7'd64;
      polarity_r      <= 1'b0;
      addr_mode_r     <= MODE_PAGE;
      seg_remap_r     <= 1'b0;
      com_flip_r      <= 1'b0;
      params_left_r   <= 2'd0;
      pend_cmd_r      <= 8'd0;
      param_cnt_r     <= 2'd0;
      win_col_start_r <= 8'd0;
      win_col_end_r   <= RST_COL_END;
      win_row_start_r <= 12'd0;
      win_row_end_r   <= RST_ROW_END;
      cur_col_r       <= 8'd0;
      cur_row_r       <= 12'd0;
      col_low_r       <= 4'd0;
      col_high_r      <= 4'd0;
      disp_en_r       <= 1'b0;
      inv_r           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:    width_r <= cfg_wdata;
          CFG_HEIGHT:   height_r <= cfg_wdata[6:0];
          CFG_POLARITY: polarity_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        addr_mode_r     <= addr_mode_nxt;
        seg_remap_r     <= seg_remap_nxt;
        com_flip_r      <= com_flip_nxt;
        params_left_r   <= params_left_nxt;
        pend_cmd_r      <= pend_cmd_nxt;
        param_cnt_r     <= param_cnt_nxt;
        win_col_start_r <= win_col_start_nxt;
        win_col_end_r   <= win_col_end_nxt;
        win_row_start_r <= win_row_start_nxt;
        win_row_end_r   <= win_row_end_nxt;
        cur_col_r       <= cur_col_nxt;
        cur_row_r       <= cur_row_nxt;
        col_low_r       <= col_low_nxt;
        col_high_r      <= col_high_nxt;
        disp_en_r       <= disp_en_nxt;
        inv_r           <= inv_nxt;
      end
    end
  end

endmodule

// ===== design/ogw_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogw_fifo
// Short job queue between the decoder and the pixel emitter.
// ----------------------------------------------------------------------------
module ogw_fifo
  import ogw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  job_t     wr_job,
  output logic     full,
  input  logic     pop,
  output logic     rd_valid,
  output job_t     rd_job
);

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 do_pop;

  assign full     = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (FIFO_AW + 1)'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (FIFO_AW)'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + (FIFO_AW)'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== design/ogw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogw_back
// Pixel emitter: expands the job at the queue head into result beats, one
// per cycle unless out_ready stalls it, into a registered output stage.
// ----------------------------------------------------------------------------
module ogw_back
  import ogw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  job_t q_job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [2:0] bit_r, bit_nxt;
  logic       out_valid_r;
  out_t       out_r;
  out_t       res;
  logic       emit;
  logic [3:0] cnt_m1;

  assign emit      = q_valid && (!out_valid_r || out_ready);
  assign cnt_m1    = q_job.cnt - 4'd1;
  assign pop       = emit && res.last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    res.write_valid = 1'b0;
    res.pixel_row   = 6'd0;
    res.pixel_col   = 7'd0;
    res.pixel_on    = 1'b0;
    res.screen_on   = q_job.disp;
    res.inverted    = q_job.inv;
    res.last        = 1'b1;
    if (q_job.cnt != 4'd0) begin
      res.write_valid = 1'b1;
      res.pixel_row   = q_job.flip ? q_job.row0 - {3'd0, bit_r}
                                   : q_job.row0 + {3'd0, bit_r};
      res.pixel_col   = q_job.col;
      res.pixel_on    = q_job.data[bit_r];
      res.last        = ({1'b0, bit_r} == cnt_m1);
    end
    bit_nxt = bit_r;
    if (emit) begin
      bit_nxt = res.last ? 3'd0 : bit_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  a_bit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_job.cnt != 4'd0) |-> ({1'b0, bit_r} < q_job.cnt))
    else $error("pixel index past the job's pixel count");

  a_bit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.last) |=> (bit_r == 3'd0))
    else $error("pixel index not restarted after final beat");

  a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_valid) |-> out_r.last)
    else $error("non-writing beat not marked last");

endmodule

// ===== design/oled_command_and_gddram_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_command_and_gddram_writer
// Controller side of a monochrome OLED panel: decodes command and data beats
// and writes display data as pixel beats at the cursor.
//
//   Channel  Handshake            Payload
//   in_      in_valid/in_ready    in_data  (func, byte_value)
//   out_     out_valid/out_ready  out_data (pixel write and display state)
//   cfg_     cfg_we               cfg_index, cfg_wdata
//
// A command beat yields one result beat; a data beat yields one result beat
// per visible pixel (one to eight), or one non-writing beat.
// The emitter issues one result beat per cycle unless out_ready stalls it;
// the decoder takes one input beat per cycle while the queue is not full.
// A four-entry job queue lets input continue while the emitter is busy.
// Reset is synchronous and needs no clearing pass.
// With out_ready low the output register holds and input stalls once the
// queue is full.
// ----------------------------------------------------------------------------
module oled_command_and_gddram_writer
  import ogw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic     in_push;
  logic     q_full;
  job_t     new_job;
  job_t     head_job;
  logic     head_valid;
  logic     pop;

  assign in_ready = !q_full;
  assign in_push  = in_valid && in_ready;

  ogw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_push),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job       (new_job)
  );

  ogw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .wr_job   (new_job),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (head_valid),
    .rd_job   (head_job)
  );

  ogw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_job     (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
